// File: rtl/core/deq_pkg.sv
// Shared types and constants of the double-ended queue core.
package deq_pkg;

    // Default configuration
    localparam int DEQ_DEPTH       = 1024;
    localparam int DEQ_VALUE_WIDTH = 32;

    // Fixed field widths on the item channels
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Operation codes; codes above MODE_QUERY act as a query
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_QUERY      = 3'd4
    } t_mode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

// File: rtl/core/deq_cmd_if.sv
// Command channel of the double-ended queue: operation and value.
interface deq_cmd_if import deq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output mode, output item_value, input ready);
    modport sink   (input valid, input mode, input item_value, output ready);

endinterface

// File: rtl/core/deq_rsp_if.sv
// Response channel of the double-ended queue: pop result and queue status.
interface deq_rsp_if import deq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;

    modport source (
        output valid, output popped_value, output status, output entry_count,
        output is_empty, output front_value, output back_value, input ready
    );
    modport sink (
        input valid, input popped_value, input status, input entry_count,
        input is_empty, input front_value, input back_value, output ready
    );

endinterface

// File: rtl/core/deq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/double_ended_queue_core.sv
// Bounded double-ended queue held in a ring buffer RAM of DEPTH entries, with a head
// index, a back index and an entry count in registers, and the front and back values
// cached beside the RAM. Each command item (push front, push back, pop front, pop back,
// query) yields exactly one response item with the popped value, a status, the entry
// count, an empty flag and the front and back values after the operation. Pushes,
// queries, failed pops and pops that empty the queue load the response directly; a pop
// that leaves entries first passes a read state, since the new front or back entry is
// fetched through the RAM's registered read port before the response is formed. A
// stalled response register holds off new commands, and a read waits in a hold state.
// Stored values are VALUE_WIDTH bits and are sign-extended or cut to 32 bits when
// reported. The RAM needs no clearing after reset: only occupied entries are ever read.
module double_ended_queue_core import deq_pkg::*; #(
    parameter int DEPTH       = DEQ_DEPTH,
    parameter int VALUE_WIDTH = DEQ_VALUE_WIDTH
) (
    input logic      i_clk,
    input logic      i_rst_n,
    deq_cmd_if.sink  i_cmd,
    deq_rsp_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    // Sign-extend or cut a stored value to the reported width
    function automatic logic signed [DATA_W-1:0] widen(input logic [VW-1:0] v);
        return DATA_W'(signed'(v));
    endfunction

    // Ring index step forward / backward
    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    t_state                   r_state;
    logic [AW-1:0]            r_head;
    logic [AW-1:0]            r_tail;
    logic [CW-1:0]            r_count;
    logic [VW-1:0]            r_front;
    logic [VW-1:0]            r_back;
    logic                     r_rd_front;
    logic [VW-1:0]            r_popped;
    t_status                  r_status;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_popped;
    t_status                  r_out_status;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_empty;
    logic signed [DATA_W-1:0] r_out_front;
    logic signed [DATA_W-1:0] r_out_back;

    logic                     out_free;
    logic                     cmd_fire;
    t_mode                    cmd_mode;
    logic [VW-1:0]            cmd_val;

    logic [AW-1:0]            n_head;
    logic [AW-1:0]            n_tail;
    logic [CW-1:0]            n_count;
    logic [VW-1:0]            n_front;
    logic [VW-1:0]            n_back;
    logic [VW-1:0]            op_popped;
    t_status                  op_status;
    logic                     op_wr;
    logic                     op_rd;

    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [VW-1:0]            ram_rd_data;

    logic                     ld_en;
    logic [VW-1:0]            ld_popped;
    t_status                  ld_status;
    logic [CW-1:0]            ld_count;
    logic [VW-1:0]            ld_front;
    logic [VW-1:0]            ld_back;

    // Handshake
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;
    assign cmd_mode    = t_mode'(i_cmd.mode);
    assign cmd_val     = VW'(i_cmd.item_value);

    // Operation decode: next indices, count, cached ends and RAM access
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        op_popped   = '0;
        op_status   = ST_DONE;
        op_wr       = 1'b0;
        op_rd       = 1'b0;
        ram_wr_addr = idx_dec(r_head);
        ram_rd_addr = idx_inc(r_head);
        case (cmd_mode)
            MODE_PUSH_FRONT: begin
                if (r_count == CW'(DEPTH)) begin
                    op_status = ST_FULL;
                end else begin
                    op_wr   = 1'b1;
                    n_head  = idx_dec(r_head);
                    n_count = r_count + CW'(1);
                    n_front = cmd_val;
                    if (r_count == '0) begin
                        n_back = cmd_val;
                    end
                end
            end
            MODE_PUSH_BACK: begin
                ram_wr_addr = idx_inc(r_tail);
                if (r_count == CW'(DEPTH)) begin
                    op_status = ST_FULL;
                end else begin
                    op_wr   = 1'b1;
                    n_tail  = idx_inc(r_tail);
                    n_count = r_count + CW'(1);
                    n_back  = cmd_val;
                    if (r_count == '0) begin
                        n_front = cmd_val;
                    end
                end
            end
            MODE_POP_FRONT: begin
                if (r_count == '0) begin
                    op_status = ST_EMPTY;
                end else begin
                    op_popped = r_front;
                    n_head    = idx_inc(r_head);
                    n_count   = r_count - CW'(1);
                    op_rd     = (r_count != CW'(1));
                end
            end
            MODE_POP_BACK: begin
                ram_rd_addr = idx_dec(r_tail);
                if (r_count == '0) begin
                    op_status = ST_EMPTY;
                end else begin
                    op_popped = r_back;
                    n_tail    = idx_dec(r_tail);
                    n_count   = r_count - CW'(1);
                    op_rd     = (r_count != CW'(1));
                end
            end
            MODE_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    assign ram_wr_en = cmd_fire && op_wr;
    assign ram_rd_en = cmd_fire && op_rd;

    // Response register load source per state
    always_comb begin
        ld_en     = 1'b0;
        ld_popped = r_popped;
        ld_status = r_status;
        ld_count  = r_count;
        ld_front  = r_front;
        ld_back   = r_back;
        case (r_state)
            S_IDLE: begin
                ld_en     = cmd_fire && !op_rd;
                ld_popped = op_popped;
                ld_status = op_status;
                ld_count  = n_count;
                ld_front  = n_front;
                ld_back   = n_back;
            end
            S_READ: begin
                ld_en = out_free;
                if (r_rd_front) begin
                    ld_front = ram_rd_data;
                end else begin
                    ld_back = ram_rd_data;
                end
            end
            S_HOLD: begin
                ld_en = out_free;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, queue state and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= AW'(DEPTH - 1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_head   <= n_head;
                        r_tail   <= n_tail;
                        r_count  <= n_count;
                        r_front  <= n_front;
                        r_back   <= n_back;
                        r_popped <= op_popped;
                        r_status <= op_status;
                        if (op_rd) begin
                            r_rd_front <= (cmd_mode == MODE_POP_FRONT);
                            r_state    <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_front <= ld_front;
                    r_back  <= ld_back;
                    r_state <= out_free ? S_IDLE : S_HOLD;
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (ld_en) begin
                r_out_valid  <= 1'b1;
                r_out_popped <= (ld_status == ST_DONE) ? widen(ld_popped) : '0;
                r_out_status <= ld_status;
                r_out_count  <= COUNT_W'(ld_count);
                r_out_empty  <= (ld_count == '0);
                r_out_front  <= (ld_count == '0) ? '0 : widen(ld_front);
                r_out_back   <= (ld_count == '0) ? '0 : widen(ld_back);
            end
        end
    end

    // Ring storage
    deq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (cmd_val),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Response outputs
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_out_popped;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = r_out_count;
    assign o_rsp.is_empty     = r_out_empty;
    assign o_rsp.front_value  = r_out_front;
    assign o_rsp.back_value   = r_out_back;

`ifndef SYNTHESIS
    // Count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // A RAM read is always consumed in the read state next cycle
    a_read_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_rd_en |=> (r_state == S_READ))
        else $error("RAM read not followed by read state");

    // Writes only from idle and never together with a read
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> ((r_state == S_IDLE) && !ram_rd_en))
        else $error("RAM write outside idle or with a read");

    // A fetch of a new end only happens with entries left
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_count != '0))
        else $error("end fetch on empty queue");
`endif

endmodule

// File: test/double_ended_queue_core_tb.sv
// Self-checking testbench of the double-ended queue core.
`timescale 1ns / 100ps

module double_ended_queue_core_tb import deq_pkg::*; ();

    localparam int DEPTH          = DEQ_DEPTH;
    localparam int VALUE_WIDTH    = DEQ_VALUE_WIDTH;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    // Highest code the mode field can carry; codes above MODE_QUERY act as a query
    localparam logic [MODE_W-1:0] MODE_CODE_TOP = '1;

    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct {
        logic signed [DATA_W-1:0] popped_value;
        t_status                  status;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } t_deq_rsp;

    // Shadow queue plus the responses it predicts, oldest first
    class deq_response_checker;
        logic [VALUE_WIDTH-1:0] shadow_entries[$];
        t_deq_rsp               pending_responses[$];
        int mismatches;
        int commands_noted;
        int responses_checked;
        int full_drops;
        int empty_pops;
        int peak_count;

        // Stored values come back sign-extended to the channel width
        function logic signed [DATA_W-1:0] as_reported(logic [VALUE_WIDTH-1:0] v);
            return DATA_W'($signed(v));
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic signed [DATA_W-1:0] value);
            t_deq_rsp               want;
            logic [VALUE_WIDTH-1:0] stored;
            stored            = VALUE_WIDTH'(value);
            want.popped_value = '0;
            want.status       = ST_DONE;
            commands_noted++;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (shadow_entries.size() >= DEPTH) begin
                        want.status = ST_FULL;
                        full_drops++;
                    end else if (mode == MODE_PUSH_FRONT) begin
                        shadow_entries.insert(0, stored);
                    end else begin
                        shadow_entries.insert(shadow_entries.size(), stored);
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    if (shadow_entries.size() == 0) begin
                        want.status = ST_EMPTY;
                        empty_pops++;
                    end else if (mode == MODE_POP_FRONT) begin
                        want.popped_value = as_reported(shadow_entries[0]);
                        shadow_entries.delete(0);
                    end else begin
                        want.popped_value = as_reported(shadow_entries[$]);
                        shadow_entries.delete(shadow_entries.size() - 1);
                    end
                end
                default: ;  // query and unused codes leave the queue alone
            endcase
            want.entry_count = COUNT_W'(shadow_entries.size());
            want.is_empty    = (shadow_entries.size() == 0);
            want.front_value = '0;
            want.back_value  = '0;
            if (shadow_entries.size() != 0) begin
                want.front_value = as_reported(shadow_entries[0]);
                want.back_value  = as_reported(shadow_entries[$]);
            end
            if (shadow_entries.size() > peak_count) peak_count = shadow_entries.size();
            pending_responses.insert(pending_responses.size(), want);
        endfunction

        function void compare_field(string field, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] seen);
            if (seen !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_response(t_deq_rsp seen);
            t_deq_rsp want;
            responses_checked++;
            if (pending_responses.size() == 0) begin
                $error("response item with no command waiting for it");
                mismatches++;
                return;
            end
            want = pending_responses[0];
            pending_responses.delete(0);
            compare_field("popped_value", want.popped_value, seen.popped_value);
            compare_field("status",       DATA_W'(want.status),      DATA_W'(seen.status));
            compare_field("entry_count",  DATA_W'(want.entry_count), DATA_W'(seen.entry_count));
            compare_field("is_empty",     DATA_W'(want.is_empty),    DATA_W'(seen.is_empty));
            compare_field("front_value",  want.front_value,  seen.front_value);
            compare_field("back_value",   want.back_value,   seen.back_value);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    deq_cmd_if cmd_bus ();
    deq_rsp_if rsp_bus ();

    deq_response_checker scoreboard = new();

    bit hold_request;
    int cmd_calm;
    int rsp_calm;
    int idle_cycles;

    double_ended_queue_core #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always #10 i_clk = ~i_clk;

    // Gap before an item, with occasional calm stretches in which there is none
    function automatic int pick_gap(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 40);
        return $urandom_range(0, 4);
    endfunction

    // Mostly random bits, sometimes an extreme
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return '0;
            3:       return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_push();
        return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    endfunction

    function automatic logic [MODE_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    endfunction

    // Push share drives the occupancy; the rest is pops plus a few queries
    function automatic logic [MODE_W-1:0] pick_mode(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return pick_push();
        if (r < 92) return pick_pop();
        return MODE_W'($urandom_range(MODE_QUERY, MODE_CODE_TOP));
    endfunction

    // Offer one command item; starts and returns on a falling edge
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        gap = pick_gap(cmd_calm);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.mode       <= mode;
        cmd_bus.item_value <= value;
        do @(posedge i_clk); while (!cmd_bus.ready);
        @(negedge i_clk);
    endtask

    // Monitor: responses are checked before the command of the same edge is noted
    always @(posedge i_clk) begin
        t_deq_rsp seen;
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                seen.popped_value = rsp_bus.popped_value;
                seen.status       = t_status'(rsp_bus.status);
                seen.entry_count  = rsp_bus.entry_count;
                seen.is_empty     = rsp_bus.is_empty;
                seen.front_value  = rsp_bus.front_value;
                seen.back_value   = rsp_bus.back_value;
                scoreboard.check_response(seen);
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                scoreboard.note_command(cmd_bus.mode, cmd_bus.item_value);
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Response side: random stalls, plus one long hold on request
    initial begin : response_sink
        int gap;
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = pick_gap(rsp_calm);
            end
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int episode_left;
        int push_pct;
        cmd_bus.valid      = 1'b0;
        cmd_bus.mode       = MODE_QUERY;
        cmd_bus.item_value = '0;
        episode_left       = 0;
        push_pct           = 50;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty pops, extremes, head wrap on first front push, unused codes
        send_command(MODE_POP_FRONT, VALUE_MAX);
        send_command(MODE_POP_BACK, VALUE_MIN);
        send_command(MODE_QUERY, '1);
        send_command(MODE_PUSH_BACK, VALUE_MAX);
        send_command(MODE_PUSH_FRONT, VALUE_MIN);
        send_command(MODE_PUSH_BACK, '0);
        send_command(MODE_PUSH_FRONT, '1);
        send_command(MODE_QUERY, VALUE_MIN);
        for (int m = MODE_QUERY + 1; m <= MODE_CODE_TOP; m++) begin
            send_command(MODE_W'(m), pick_value());
        end
        send_command(MODE_POP_BACK, '1);
        send_command(MODE_POP_FRONT, '0);
        send_command(MODE_POP_BACK, VALUE_MAX);
        send_command(MODE_POP_FRONT, VALUE_MIN);
        send_command(MODE_POP_FRONT, '0);
        // Single entry taken from the opposite end it went in
        send_command(MODE_PUSH_FRONT, pick_value());
        send_command(MODE_POP_BACK, '0);
        send_command(MODE_PUSH_BACK, pick_value());
        send_command(MODE_POP_FRONT, '0);
        send_command(MODE_POP_BACK, '0);

        // Random episodes of growth, balance and drain; the sink holds off early on
        hold_request = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (episode_left == 0) begin
                episode_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 75;
                endcase
            end
            episode_left--;
            send_command(pick_mode(push_pct), pick_value());
        end
        cmd_bus.valid <= 1'b0;

        // Wait for outstanding responses, then a few cycles for strays
        while (scoreboard.pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d commands and %0d responses, peak occupancy %0d of %0d.",
                 scoreboard.commands_noted, scoreboard.responses_checked,
                 scoreboard.peak_count, DEPTH);
        $display("Pushes dropped on a full queue: %0d; pops on an empty queue: %0d.",
                 scoreboard.full_drops, scoreboard.empty_pops);
        if (scoreboard.mismatches == 0 && scoreboard.pending_responses.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/deq_pkg.sv
rtl/core/deq_cmd_if.sv
rtl/core/deq_rsp_if.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue_core.sv
test/double_ended_queue_core_tb.sv
